// File: hw/rtl/cpd_pkg.sv
package cpd_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int PAL_BYTES = PALETTE_ENTRIES * 3;

   // address / 3 as (address * 683) >> 11, exact for addresses below 1024
   localparam int RECIP3 = 683;
   localparam int RECIP3_SHIFT = 11;

   localparam logic [7:0] END_MARK = 8'hFF;

   localparam logic [1:0] COMP_RED = 2'd0;
   localparam logic [1:0] COMP_GREEN = 2'd1;
   localparam logic [1:0] COMP_BLUE = 2'd2;

   typedef enum logic [1:0] {
      FUNC_PAL_WRITE = 2'd0,
      FUNC_COL_START = 2'd1,
      FUNC_DATA      = 2'd2
   } func_type;

   typedef enum logic [5:0] {
      PH_ENDED = 6'b000001,
      PH_TOP   = 6'b000010,
      PH_LEN   = 6'b000100,
      PH_JUNK  = 6'b001000,
      PH_PIX   = 6'b010000,
      PH_TAIL  = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      CSR_TEX_WIDTH  = 2'd0,
      CSR_TEX_HEIGHT = 2'd1,
      CSR_DEST_X     = 2'd2,
      CSR_DEST_Y     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              we;
      logic [PAL_AW-1:0] row;
      logic [1:0]        comp;
      logic [7:0]        value;
   } pal_wr_type;

   typedef struct packed {
      logic              hit;
      logic              ok;
      logic [PAL_AW-1:0] row;
      logic [12:0]       py;
      logic [12:0]       px;
   } pix_type;

   typedef struct packed {
      logic in_pix;
      logic left_zero;
   } parse_status_type;

endpackage

// File: hw/rtl/cpd_palette.sv
module cpd_palette (
   input  logic                       clock,
   input  logic                       reset,
   input  cpd_pkg::pal_wr_type        pal_wr,
   input  logic                       rd_en,
   input  logic [cpd_pkg::PAL_AW-1:0] rd_row,
   input  logic                       rd_ok,
   output logic [7:0]                 red,
   output logic [7:0]                 green,
   output logic [7:0]                 blue
);
   import cpd_pkg::*;

   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [7:0] red_mem [PALETTE_ENTRIES];
   logic [7:0] green_mem [PALETTE_ENTRIES];
   logic [7:0] blue_mem [PALETTE_ENTRIES];
   logic [7:0] red_rd_ff;
   logic [7:0] green_rd_ff;
   logic [7:0] blue_rd_ff;
   logic       rd_ok_ff;
   logic       wr_row_valid;

   assign wr_row_valid = valid_ff[pal_wr.row];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pal_wr.we) begin
         valid_ff[pal_wr.row] <= 1'b1;
      end
   end

   // first write to a row zeroes the other two lanes
   always_ff @(posedge clock) begin
      if (pal_wr.we) begin
         if (pal_wr.comp == COMP_RED) begin
            red_mem[pal_wr.row] <= pal_wr.value;
         end else if (!wr_row_valid) begin
            red_mem[pal_wr.row] <= '0;
         end
         if (pal_wr.comp == COMP_GREEN) begin
            green_mem[pal_wr.row] <= pal_wr.value;
         end else if (!wr_row_valid) begin
            green_mem[pal_wr.row] <= '0;
         end
         if (pal_wr.comp == COMP_BLUE) begin
            blue_mem[pal_wr.row] <= pal_wr.value;
         end else if (!wr_row_valid) begin
            blue_mem[pal_wr.row] <= '0;
         end
      end
      if (rd_en) begin
         red_rd_ff   <= red_mem[rd_row];
         green_rd_ff <= green_mem[rd_row];
         blue_rd_ff  <= blue_mem[rd_row];
         rd_ok_ff    <= rd_ok && valid_ff[rd_row];
      end
   end

   assign red   = rd_ok_ff ? red_rd_ff : '0;
   assign green = rd_ok_ff ? green_rd_ff : '0;
   assign blue  = rd_ok_ff ? blue_rd_ff : '0;

endmodule

// File: hw/rtl/cpd_parse.sv
module cpd_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      req_valid,
   input  logic [1:0]                req_func,
   input  logic [9:0]                req_palette_address,
   input  logic [7:0]                req_palette_value,
   input  logic [14:0]               req_column,
   input  logic [7:0]                req_data_byte,
   input  logic [12:0]               tex_width,
   input  logic [12:0]               tex_height,
   input  logic signed [15:0]        dest_x,
   input  logic signed [15:0]        dest_y,
   output cpd_pkg::pal_wr_type       pal_wr,
   output cpd_pkg::pix_type          pix,
   output cpd_pkg::parse_status_type status
);
   import cpd_pkg::*;

   logic        s1_valid_ff;
   logic [1:0]  s1_func_ff;
   logic [9:0]  s1_paddr_ff;
   logic [7:0]  s1_pval_ff;
   logic [14:0] s1_col_ff;
   logic [7:0]  s1_byte_ff;

   phase_type   phase_ff, phase_in;
   logic [8:0]  row_ff, row_in;
   logic [7:0]  left_ff, left_in;
   logic [14:0] column_ff, column_in;

   logic        fire;
   logic        fire_data;
   logic [19:0] addr_prod;
   logic [8:0]  addr_q;
   logic [9:0]  addr_rem;
   logic signed [17:0] py_s;
   logic signed [17:0] px_s;
   logic        in_y;
   logic        in_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && req_valid) begin
         s1_func_ff  <= req_func;
         s1_paddr_ff <= req_palette_address;
         s1_pval_ff  <= req_palette_value;
         s1_col_ff   <= req_column;
         s1_byte_ff  <= req_data_byte;
      end
   end

   assign fire      = s1_valid_ff && en;
   assign fire_data = fire && (s1_func_ff == FUNC_DATA);

   // split byte address into entry and component
   assign addr_prod = 20'(s1_paddr_ff) * 20'(RECIP3);
   assign addr_q    = 9'(addr_prod >> RECIP3_SHIFT);
   assign addr_rem  = s1_paddr_ff - ({addr_q, 1'b0} + {1'b0, addr_q});

   assign pal_wr.we    = fire && (s1_func_ff == FUNC_PAL_WRITE)
                         && (s1_paddr_ff < 10'(PAL_BYTES));
   assign pal_wr.row   = addr_q[PAL_AW-1:0];
   assign pal_wr.comp  = addr_rem[1:0];
   assign pal_wr.value = s1_pval_ff;

   assign py_s = $signed({9'd0, row_ff}) + $signed({{2{dest_y[15]}}, dest_y});
   assign px_s = $signed({3'd0, column_ff}) + $signed({{2{dest_x[15]}}, dest_x});
   assign in_y = !py_s[17] && (py_s[16:0] < {4'd0, tex_height});
   assign in_x = !px_s[17] && (px_s[16:0] < {4'd0, tex_width});

   assign pix.hit = fire_data && (phase_ff == PH_PIX) && in_y && in_x;
   assign pix.ok  = {1'b0, s1_byte_ff} < 9'(PALETTE_ENTRIES);
   assign pix.row = s1_byte_ff[PAL_AW-1:0];
   assign pix.py  = py_s[12:0];
   assign pix.px  = px_s[12:0];

   assign status.in_pix    = (phase_ff == PH_PIX);
   assign status.left_zero = (left_ff == '0);

   always_comb begin
      phase_in  = phase_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      column_in = column_ff;
      if (fire && (s1_func_ff == FUNC_COL_START)) begin
         column_in = s1_col_ff;
         phase_in  = PH_TOP;
      end else if (fire_data) begin
         unique case (phase_ff)
            PH_TOP: begin
               if (s1_byte_ff == END_MARK) begin
                  phase_in = PH_ENDED;
               end else begin
                  row_in   = {1'b0, s1_byte_ff};
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               left_in  = s1_byte_ff;
               phase_in = PH_JUNK;
            end
            PH_JUNK: begin
               phase_in = (left_ff == '0) ? PH_TAIL : PH_PIX;
            end
            PH_PIX: begin
               row_in  = row_ff + 9'd1;
               left_in = left_ff - 8'd1;
               if (left_in == '0) begin
                  phase_in = PH_TAIL;
               end
            end
            PH_TAIL: begin
               phase_in = PH_TOP;
            end
            PH_ENDED: begin
               phase_in = PH_ENDED;
            end
            default: begin
               phase_in = PH_ENDED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ENDED;
         row_ff    <= '0;
         left_ff   <= '0;
         column_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         row_ff    <= row_in;
         left_ff   <= left_in;
         column_ff <= column_in;
      end
   end

endmodule

// File: hw/rtl/column_post_palette_decoder_core.sv
// An input transfer is registered at the parser input, then in the multiply and
// palette read stage, then in the output register that drives rsp_valid.
// Throughput: one item per cycle; the whole pipeline holds only while a
// result waits on rsp_stall.
// Reset: synchronous, active high; parser waits for a column start, the
// palette reads as zero until written, geometry returns to 64 x 128 at 0,0.
module column_post_palette_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [9:0]  req_palette_address,
   input  logic [7:0]  req_palette_value,
   input  logic [14:0] req_column,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_pixel_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import cpd_pkg::*;

   logic [12:0]        tex_width_ff;
   logic [12:0]        tex_height_ff;
   logic signed [15:0] dest_x_ff;
   logic signed [15:0] dest_y_ff;

   logic             en;
   pal_wr_type       pal_wr;
   pix_type          pix;
   parse_status_type status;

   logic        s2_valid_ff;
   logic [25:0] s2_prod_ff;
   logic [12:0] s2_px_ff;
   logic [7:0]  pal_red;
   logic [7:0]  pal_green;
   logic [7:0]  pal_blue;

   logic        rsp_valid_ff;
   logic [23:0] rsp_index_ff;
   logic [7:0]  rsp_red_ff;
   logic [7:0]  rsp_green_ff;
   logic [7:0]  rsp_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= 13'd64;
         tex_height_ff <= 13'd128;
         dest_x_ff     <= '0;
         dest_y_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:  tex_width_ff  <= csr_wdata[12:0];
            CSR_TEX_HEIGHT: tex_height_ff <= csr_wdata[12:0];
            CSR_DEST_X:     dest_x_ff     <= csr_wdata;
            CSR_DEST_Y:     dest_y_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance every stage unless a finished pixel is held
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   cpd_parse u_parse (
      .clock               (clock),
      .reset               (reset),
      .en                  (en),
      .req_valid           (req_valid),
      .req_func            (req_func),
      .req_palette_address (req_palette_address),
      .req_palette_value   (req_palette_value),
      .req_column          (req_column),
      .req_data_byte       (req_data_byte),
      .tex_width           (tex_width_ff),
      .tex_height          (tex_height_ff),
      .dest_x              (dest_x_ff),
      .dest_y              (dest_y_ff),
      .pal_wr              (pal_wr),
      .pix                 (pix),
      .status              (status)
   );

   cpd_palette u_palette (
      .clock  (clock),
      .reset  (reset),
      .pal_wr (pal_wr),
      .rd_en  (pix.hit),
      .rd_row (pix.row),
      .rd_ok  (pix.ok),
      .red    (pal_red),
      .green  (pal_green),
      .blue   (pal_blue)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff  <= pix.hit;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en && pix.hit) begin
         s2_prod_ff <= 26'(pix.py) * 26'(tex_width_ff);
         s2_px_ff   <= pix.px;
      end
      if (en && s2_valid_ff) begin
         rsp_index_ff <= 24'(s2_prod_ff + 26'(s2_px_ff));
         rsp_red_ff   <= pal_red;
         rsp_green_ff <= pal_green;
         rsp_blue_ff  <= pal_blue;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_red         = rsp_red_ff;
   assign rsp_green       = rsp_green_ff;
   assign rsp_blue        = rsp_blue_ff;

`ifndef ASSERT_OFF
   a_pix_left: assert property (@(posedge clock) disable iff (reset)
      status.in_pix |-> !status.left_zero)
      else $error("post body phase with no pixels left");

   a_hit_in_tex: assert property (@(posedge clock) disable iff (reset)
      pix.hit |-> (pix.py < tex_height_ff) && (pix.px < tex_width_ff))
      else $error("pixel hit outside texture");

   a_s2_to_rsp: assert property (@(posedge clock) disable iff (reset)
      en && s2_valid_ff |=> rsp_valid)
      else $error("pixel lost between multiply stage and output");
`endif

endmodule
